@@ design/oale_pkg.sv @@
// shared types and constants for the ordered list engine
package oale_pkg;

    // field widths fixed by the interface
    localparam int POS_W   = 9;
    localparam int CNT_W   = 9;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 9;
    localparam int GROUP   = 16;

    typedef enum logic [2:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_READ   = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_REMOVE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OOB   = 2'd3
    } status_t;

    // per-cycle command broadcast to every entry cell
    typedef struct packed {
        logic push;
        logic insert;
        logic remove;
        logic read;
    } cell_cmd_t;

endpackage

@@ design/oale_cell.sv @@
// one entry cell of the list: holds a value and trades it with its neighbors
module oale_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int IW          = 9,
    parameter int INDEX       = 0
) (
    input  logic                     clk,
    input  oale_pkg::cell_cmd_t      cmd,
    input  logic [IW-1:0]            key,
    input  logic [VALUE_WIDTH-1:0]   din,
    input  logic [VALUE_WIDTH-1:0]   left,
    input  logic [VALUE_WIDTH-1:0]   right,
    output logic [VALUE_WIDTH-1:0]   value,
    output logic [VALUE_WIDTH-1:0]   rd_value
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   hit;
    logic                   above;

    assign hit   = (key == MY_IDX);
    assign above = (MY_IDX > key);

    always_comb
    begin
        value_next = value_reg;
        if ((cmd.push || cmd.insert) && hit)
        begin
            value_next = din;
        end
        else if (cmd.insert && above)
        begin
            // make room: take the entry below
            value_next = left;
        end
        else if (cmd.remove && (hit || above))
        begin
            // close the gap: take the entry above
            value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value    = value_reg;
    assign rd_value = (cmd.read && hit) ? value_reg : '0;

endmodule

@@ design/ordered_array_list_engine_unit.sv @@
// ordered list engine top level: request decode, cell row, read tree, result register
// an accepted request passes through the stage 1 register and then the result register to out_valid
// throughput: one request per cycle while in_stall is low; the two-stage registered read tree sets the latency
// entry cells shift on the accept edge, so back-to-back inserts and removes chain freely
// reset clears the entry count, capacity register (to 256) and all valid flags
// entry contents are not reset and are defined only once written
module ordered_array_list_engine_unit #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: capacity register
    input  logic                          cfg_wr_en,
    input  logic [oale_pkg::CAP_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    mode,
    input  logic [oale_pkg::POS_W-1:0]    position,
    input  logic [oale_pkg::DATA_W-1:0]   value_in,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [oale_pkg::DATA_W-1:0]   value_out,
    output logic [oale_pkg::CNT_W-1:0]    count_out
);

    // index width wide enough for both the cell row and the 9-bit keys
    localparam int IW      = ($clog2(DEPTH) > oale_pkg::POS_W) ? $clog2(DEPTH)
                                                              : oale_pkg::POS_W;
    // largest count that can ever be reached
    localparam int CAP_LIM = (DEPTH > 511) ? 511 : DEPTH;
    // value bits carried across the 32-bit ports
    localparam int CW      = (VALUE_WIDTH < oale_pkg::DATA_W) ? VALUE_WIDTH
                                                              : oale_pkg::DATA_W;
    // read tree: first level ORs groups of cells, second level ORs the groups
    localparam int NG      = (DEPTH + oale_pkg::GROUP - 1) / oale_pkg::GROUP;

    localparam logic [oale_pkg::CAP_W-1:0] CAP_MAX = oale_pkg::CAP_W'(CAP_LIM);

    // ------------------------------------------------------------------
    // capacity register and entry count
    // ------------------------------------------------------------------
    logic [oale_pkg::CAP_W-1:0] max_entries_reg;
    logic [oale_pkg::CNT_W-1:0] count_reg;
    logic [oale_pkg::CNT_W-1:0] count_next;
    logic [oale_pkg::CAP_W-1:0] cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    // capacity saturated to the physical row length
    assign cap = (max_entries_reg > CAP_MAX) ? CAP_MAX : max_entries_reg;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic accept;

    // stage 1 moves into the result register when that is empty or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // request decode: status, count update and the cell command
    // ------------------------------------------------------------------
    oale_pkg::status_t    req_status;
    oale_pkg::cell_cmd_t  cmd;
    oale_pkg::cell_cmd_t  cmd_req;
    logic [oale_pkg::CNT_W-1:0] key9;
    logic [IW-1:0]        key;
    logic [VALUE_WIDTH-1:0] din;

    always_comb
    begin
        req_status = oale_pkg::ST_OK;
        cmd_req    = '0;
        count_next = count_reg;
        key9       = position;
        unique case (oale_pkg::mode_t'(mode))
            oale_pkg::MODE_PUSH:
            begin
                key9 = count_reg;
                if (count_reg >= cap)
                begin
                    req_status = oale_pkg::ST_FULL;
                end
                else
                begin
                    cmd_req.push = 1'b1;
                    count_next   = count_reg + 1'b1;
                end
            end
            oale_pkg::MODE_POP:
            begin
                if (count_reg == '0)
                begin
                    req_status = oale_pkg::ST_UNDER;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            oale_pkg::MODE_READ:
            begin
                if (position >= count_reg)
                begin
                    req_status = oale_pkg::ST_OOB;
                end
                else
                begin
                    cmd_req.read = 1'b1;
                end
            end
            oale_pkg::MODE_INSERT:
            begin
                // bound is checked ahead of the full check
                if (position > count_reg)
                begin
                    req_status = oale_pkg::ST_OOB;
                end
                else if (count_reg >= cap)
                begin
                    req_status = oale_pkg::ST_FULL;
                end
                else
                begin
                    cmd_req.insert = 1'b1;
                    count_next     = count_reg + 1'b1;
                end
            end
            oale_pkg::MODE_REMOVE:
            begin
                if (position >= count_reg)
                begin
                    req_status = oale_pkg::ST_OOB;
                end
                else
                begin
                    cmd_req.remove = 1'b1;
                    count_next     = count_reg - 1'b1;
                end
            end
            default:
            begin
                // unused modes leave everything alone
                req_status = oale_pkg::ST_OK;
            end
        endcase
    end

    // cells act only on an accepted request
    assign cmd = accept ? cmd_req : '0;
    assign key = IW'(key9);

    always_comb
    begin
        din         = '0;
        din[CW-1:0] = value_in[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // row of entry cells; each one sees its two neighbors
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_rd  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_val;
        logic [VALUE_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        oale_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IW          (IW),
            .INDEX       (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .key      (key),
            .din      (din),
            .left     (left_val),
            .right    (right_val),
            .value    (cell_val[i]),
            .rd_value (cell_rd[i])
        );
    end

    // ------------------------------------------------------------------
    // read tree stage 1: OR the gated cell outputs group by group
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0]      part_reg  [NG];
    logic [VALUE_WIDTH-1:0]      part_next [NG];
    logic [1:0]                  s1_status_reg;
    logic [oale_pkg::CNT_W-1:0]  s1_count_reg;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = '0;
            for (int k = 0; k < oale_pkg::GROUP; k++)
            begin
                if (g * oale_pkg::GROUP + k < DEPTH)
                begin
                    part_next[g] = part_next[g] | cell_rd[g * oale_pkg::GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= req_status;
            s1_count_reg  <= count_next;
            part_reg      <= part_next;
        end
    end

    // ------------------------------------------------------------------
    // read tree stage 2 and result register
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0]      rd_sum;
    logic [oale_pkg::DATA_W-1:0] rd_port;
    logic [1:0]                  out_status_reg;
    logic [oale_pkg::DATA_W-1:0] out_value_reg;
    logic [oale_pkg::CNT_W-1:0]  out_count_reg;

    always_comb
    begin
        rd_sum = '0;
        for (int g = 0; g < NG; g++)
        begin
            rd_sum = rd_sum | part_reg[g];
        end
        rd_port         = '0;
        rd_port[CW-1:0] = rd_sum[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_status_reg <= s1_status_reg;
            out_value_reg  <= rd_port;
            out_count_reg  <= s1_count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign value_out = out_value_reg;
    assign count_out = out_count_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // the entry count never passes the reachable capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_MAX)
        else $error("entry count beyond capacity");

    // the request side stalls only when both stages are occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("request stalled with a free stage");

    // a request leaving stage 1 always lands in the result register
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("request lost between stages");

    // a held stage 1 request stays put
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_count_reg)))
        else $error("stage 1 request dropped while held");

endmodule

@@ tb/tb_ordered_array_list_engine_unit.sv @@
// self-checking testbench for the ordered list engine: directed, capacity and random traffic
module tb_ordered_array_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    // cycles with no request or reply moving before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // result path is two registers deep (stage 1 and the result register), so the settle wait covers anything in flight
    localparam int SETTLE_CYCLES = 6;
    // codes 5 to 7 are not decoded by the block
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int PRINT_CAP = 50;

    typedef logic [oale_pkg::POS_W-1:0] pos_t;
    typedef logic [2:0]                 mode_bits_t;
    typedef logic [IDX_W-1:0]           idx_t;

    // one expected reply of the list
    typedef struct {
        oale_pkg::status_t          status;
        logic [31:0]                value;
        logic [oale_pkg::CNT_W-1:0] count;
    } list_reply_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [oale_pkg::CAP_W-1:0]    cfg_wr_data = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic [2:0]                    mode        = '0;
    logic [oale_pkg::POS_W-1:0]    position    = '0;
    logic [oale_pkg::DATA_W-1:0]   value_in    = '0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic [1:0]                    status;
    logic [oale_pkg::DATA_W-1:0]   value_out;
    logic [oale_pkg::CNT_W-1:0]    count_out;

    // shadow of the list held by the block
    logic [31:0]         list_mem [DEPTH];
    int unsigned         list_count  = 0;
    int unsigned         capacity_reg = 256;

    // replies still owed by the block, oldest first
    list_reply_t         pending_replies [$];

    int unsigned         mismatches  = 0;
    int unsigned         replies_seen = 0;
    int unsigned         idle_pct    = 0;
    int unsigned         stall_pct   = 0;
    int unsigned         quiet_cycles = 0;

    ordered_array_list_engine_unit #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .position    (position),
        .value_in    (value_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_out   (value_out),
        .count_out   (count_out)
    );

    always #2 clk = ~clk;

    // receiver back-pressure, drawn fresh every cycle
    always @(posedge clk)
    begin
        out_stall <= rst_n && (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // apply one request to the shadow list and return the reply it owes
    function automatic list_reply_t apply_to_list(logic [2:0] m, pos_t p,
                                                  logic [31:0] v);
        list_reply_t r;
        int unsigned room;
        int unsigned k;
        r.status = oale_pkg::ST_OK;
        r.value  = '0;
        // capacity register saturates at the physical depth
        room = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        case (m)
            oale_pkg::MODE_PUSH:
            begin
                if (list_count >= room)
                    r.status = oale_pkg::ST_FULL;
                else
                begin
                    list_mem[idx_t'(list_count)] = v;
                    list_count++;
                end
            end
            oale_pkg::MODE_POP:
            begin
                if (list_count == 0)
                    r.status = oale_pkg::ST_UNDER;
                else
                    list_count--;
            end
            oale_pkg::MODE_READ:
            begin
                if (p >= list_count)
                    r.status = oale_pkg::ST_OOB;
                else
                    r.value = list_mem[idx_t'(p)];
            end
            oale_pkg::MODE_INSERT:
            begin
                // bound is checked ahead of the full check
                if (p > list_count)
                    r.status = oale_pkg::ST_OOB;
                else if (list_count >= room)
                    r.status = oale_pkg::ST_FULL;
                else
                begin
                    for (k = list_count; k > p; k--)
                        list_mem[idx_t'(k)] = list_mem[idx_t'(k - 1)];
                    list_mem[idx_t'(p)] = v;
                    list_count++;
                end
            end
            oale_pkg::MODE_REMOVE:
            begin
                if (p >= list_count)
                    r.status = oale_pkg::ST_OOB;
                else
                begin
                    for (k = p; k + 1 < list_count; k++)
                        list_mem[idx_t'(k)] = list_mem[idx_t'(k + 1)];
                    list_count--;
                end
            end
            default: ; // spare codes leave the list alone
        endcase
        r.count = list_count[oale_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] reply %0d: %s got 0x%0h expected 0x%0h",
                     $realtime, replies_seen, field, got, want);
        mismatches++;
    endtask

    // reply checker: sampled mid-cycle, the reply is taken on the next rising edge
    always @(negedge clk)
    begin
        list_reply_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected reply, status", status, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (value_out !== want.value)
                    report_mismatch("value_out", value_out, want.value);
                if (count_out !== want.count)
                    report_mismatch("count_out", count_out, want.count);
            end
            replies_seen++;
        end
    end

    // hang detector: counts cycles in which neither channel moves
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic send_request(logic [2:0] m, pos_t p, logic [31:0] v);
        bit taken;
        list_reply_t reply;
        // sender gaps, drawn per cycle
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        position <= p;
        value_in <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end
        reply = apply_to_list(m, p, v);
        pending_replies = {pending_replies, reply};
    endtask

    // stop sending and let every owed reply come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // capacity register is only written with the block idle
    task automatic write_capacity(int unsigned cap);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap[oale_pkg::CAP_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = cap & 9'h1FF;
    endtask

    // index mostly near the live range, sometimes anywhere in the field
    function automatic pos_t pick_index(int unsigned span);
        if ($urandom_range(9) == 0)
            return pos_t'($urandom_range(511));
        return pos_t'($urandom_range(span));
    endfunction

    function automatic int unsigned pick_capacity();
        case ($urandom_range(6))
            0: return 1;
            1: return $urandom_range(12, 2);
            2: return $urandom_range(64, 13);
            3: return 256;
            4: return $urandom_range(511, 257);
            5: return 0;
            default: return $urandom_range(255, 65);
        endcase
    endfunction

    // every operation on an empty and a short list, extreme values and indexes
    task automatic test_basic_operations();
        logic [2:0] spare;
        idle_pct  = 0;
        stall_pct = 0;
        // empty list corner cases
        send_request(oale_pkg::MODE_POP,    '0, '0);
        send_request(oale_pkg::MODE_READ,   '0, '0);
        send_request(oale_pkg::MODE_REMOVE, '0, '0);
        send_request(oale_pkg::MODE_INSERT, 9'd1, 32'hDEAD_BEEF);
        // value extremes
        send_request(oale_pkg::MODE_PUSH,   '0, 32'h0000_0000);
        send_request(oale_pkg::MODE_PUSH,   '0, 32'hFFFF_FFFF);
        send_request(oale_pkg::MODE_PUSH,   '0, 32'hA5A5_A5A5);
        // insert at head, at tail and in the middle
        send_request(oale_pkg::MODE_INSERT, 9'd0, 32'h1234_5678);
        send_request(oale_pkg::MODE_INSERT, 9'd4, 32'h5A5A_5A5A);
        send_request(oale_pkg::MODE_INSERT, 9'd2, 32'h8000_0001);
        // reads inside and just past the end, and at the top index
        send_request(oale_pkg::MODE_READ,   9'd0,   $urandom);
        send_request(oale_pkg::MODE_READ,   9'd5,   $urandom);
        send_request(oale_pkg::MODE_READ,   9'd6,   $urandom);
        send_request(oale_pkg::MODE_READ,   9'd511, $urandom);
        // removes at head, tail, middle and out of range
        send_request(oale_pkg::MODE_REMOVE, 9'd0,   $urandom);
        send_request(oale_pkg::MODE_REMOVE, 9'd4,   $urandom);
        send_request(oale_pkg::MODE_REMOVE, 9'd1,   $urandom);
        send_request(oale_pkg::MODE_REMOVE, 9'd511, $urandom);
        // spare codes change nothing
        for (spare = MODE_SPARE_LO; spare != 3'd0; spare++)
            send_request(spare, pos_t'($urandom_range(511)), $urandom);
        // drain to empty and underflow once more
        repeat (4) send_request(oale_pkg::MODE_POP, pos_t'($urandom_range(511)), $urandom);
    endtask

    // capacity of one and zero, bound before full, saturated capacity
    task automatic test_capacity_edges();
        int unsigned k;
        write_capacity(1);
        send_request(oale_pkg::MODE_PUSH,   '0,   32'h0000_0011);
        send_request(oale_pkg::MODE_PUSH,   '0,   32'h0000_0022);
        send_request(oale_pkg::MODE_INSERT, 9'd0, 32'h0000_0033);
        send_request(oale_pkg::MODE_INSERT, 9'd2, 32'h0000_0044);
        send_request(oale_pkg::MODE_READ,   9'd0, '0);
        write_capacity(0);
        send_request(oale_pkg::MODE_PUSH,   '0,   32'h0000_0055);
        send_request(oale_pkg::MODE_INSERT, 9'd1, 32'h0000_0066);
        send_request(oale_pkg::MODE_POP,    '0,   '0);
        send_request(oale_pkg::MODE_PUSH,   '0,   32'h0000_0077);
        send_request(oale_pkg::MODE_INSERT, 9'd0, 32'h0000_0088);
        // register above the depth behaves as full depth
        write_capacity(511);
        for (k = 0; k < DEPTH; k++)
            send_request(oale_pkg::MODE_PUSH, pos_t'($urandom_range(511)), $urandom);
        send_request(oale_pkg::MODE_PUSH,   '0,     $urandom);
        send_request(oale_pkg::MODE_INSERT, 9'd256, $urandom);
        send_request(oale_pkg::MODE_INSERT, 9'd257, $urandom);
        send_request(oale_pkg::MODE_READ,   9'd255, '0);
        send_request(oale_pkg::MODE_READ,   9'd256, '0);
        send_request(oale_pkg::MODE_REMOVE, 9'd255, '0);
        send_request(oale_pkg::MODE_INSERT, 9'd0,   32'hC0DE_0001);
        send_request(oale_pkg::MODE_READ,   9'd0,   '0);
        // capacity dropped under the count keeps the entries
        write_capacity(3);
        send_request(oale_pkg::MODE_PUSH,   '0,     $urandom);
        send_request(oale_pkg::MODE_INSERT, 9'd10,  $urandom);
        send_request(oale_pkg::MODE_READ,   9'd200, '0);
        send_request(oale_pkg::MODE_REMOVE, 9'd100, '0);
        send_request(oale_pkg::MODE_POP,    '0,     '0);
        // trim back down so random traffic starts from a short list
        write_capacity(256);
        while (list_count > 5)
            send_request(oale_pkg::MODE_REMOVE, pos_t'($urandom_range(list_count - 1)),
                         $urandom);
    endtask

    // growth (push, and insert at random positions) as the largest share, plus shrink, reads and spare codes
    task automatic run_random_mix(int unsigned n_items);
        int unsigned n;
        int unsigned pick;
        for (n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(oale_pkg::MODE_PUSH, pos_t'($urandom_range(511)), $urandom);
            else if (pick < 45)
                send_request(oale_pkg::MODE_INSERT, pick_index(list_count), $urandom);
            else if (pick < 60)
                send_request(oale_pkg::MODE_POP, pos_t'($urandom_range(511)), $urandom);
            else if (pick < 72)
                send_request(oale_pkg::MODE_REMOVE,
                             pick_index(list_count == 0 ? 0 : list_count - 1), $urandom);
            else if (pick < 95)
                send_request(oale_pkg::MODE_READ,
                             pick_index(list_count == 0 ? 0 : list_count - 1), $urandom);
            else
                send_request(mode_bits_t'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)),
                             pos_t'($urandom_range(511)), $urandom);
        end
    endtask

    // random traffic under each idle and stall profile, capacity rewritten before the first and third segment
    task automatic test_random_traffic();
        int unsigned ph;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            write_capacity(pick_capacity());
            run_random_mix(50);
            // sender holds off until every reply is back
            wait_drained();
            run_random_mix(45);
            write_capacity(pick_capacity());
            run_random_mix(80);
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_operations();
        test_capacity_edges();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/oale_pkg.sv
design/oale_cell.sv
design/ordered_array_list_engine_unit.sv
tb/tb_ordered_array_list_engine_unit.sv
